// ===== rtl/ssa_pkg.sv =====
package ssa_pkg;

    localparam int DEF_WIDTH = 32;
    localparam int MODE_W    = 2;

    typedef logic [MODE_W-1:0] t_mode;

    localparam t_mode MODE_ADD = 2'd0;
    localparam t_mode MODE_SUB = 2'd1;
    localparam t_mode MODE_MUL = 2'd2;
    localparam t_mode MODE_DIV = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    // sequencer strobes towards the datapath
    typedef struct packed {
        logic load;
        logic step;
        logic fire;
    } t_ctrl;

endpackage

// ===== rtl/ssa_ctrl.sv =====
module ssa_ctrl import ssa_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_mode i_mode,
    input  logic  i_out_free,
    output logic  o_ready,
    output t_ctrl o_ctrl
);

    localparam int               CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(WIDTH - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode) inside
                        MODE_MUL, MODE_DIV: n_state = S_RUN;
                        default:            n_state = S_FIX;
                    endcase
                end
            end
            S_RUN: begin
                if (r_cnt == LAST) n_state = S_FIX;
            end
            S_FIX: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // count steps only while iterating
    always_comb begin
        n_cnt = (r_state == S_RUN) ? r_cnt + 1'b1 : '0;
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        o_ctrl.load = (r_state == S_IDLE) && i_valid;
        o_ctrl.step = (r_state == S_RUN);
        o_ctrl.fire = (r_state == S_FIX) && i_out_free;
    end

endmodule

// ===== rtl/ssa_dp.sv =====
module ssa_dp import ssa_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  t_ctrl            i_ctrl,
    input  t_mode            i_mode,
    input  logic [WIDTH-1:0] i_operand_a,
    input  logic [WIDTH-1:0] i_operand_b,
    output logic [WIDTH-1:0] o_result,
    output logic             o_div_by_zero
);

    localparam logic [WIDTH-1:0] MSB = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

    t_mode            r_mode;
    logic [WIDTH-1:0] r_x, r_y, r_acc;
    logic             r_neg, r_dz, r_force, r_force_one;

    logic [WIDTH-1:0] a_mag, b_mag;
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH:0]   diff;
    logic [WIDTH-1:0] mul_sum;

    assign a_mag   = i_operand_a[WIDTH-1] ? (~i_operand_a + 1'b1) : i_operand_a;
    assign b_mag   = i_operand_b[WIDTH-1] ? (~i_operand_b + 1'b1) : i_operand_b;
    assign rem_sh  = {r_acc[WIDTH-2:0], r_y[WIDTH-1]};
    assign diff    = {1'b0, rem_sh} - {1'b0, r_x};
    assign mul_sum = r_acc + (r_y[0] ? r_x : '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_mode      <= i_mode;
            r_acc       <= '0;
            r_neg       <= i_operand_a[WIDTH-1] ^ i_operand_b[WIDTH-1];
            r_dz        <= (i_operand_b == '0);
            r_force     <= ((i_operand_a == MSB) || (i_operand_b == MSB)) &&
                           (i_operand_a != '0) && (i_operand_b != '0);
            r_force_one <= (i_operand_a == ONE) || (i_operand_b == ONE);
            if (i_mode == MODE_DIV) begin
                r_x <= b_mag;
                r_y <= a_mag;
            end else begin
                r_x <= i_operand_a;
                r_y <= i_operand_b;
            end
        end else if (i_ctrl.step) begin
            if (r_mode == MODE_DIV) begin
                // trial subtract; quotient bits enter at the bottom of r_y
                if (!diff[WIDTH]) begin
                    r_acc <= diff[WIDTH-1:0];
                    r_y   <= {r_y[WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= rem_sh;
                    r_y   <= {r_y[WIDTH-2:0], 1'b0};
                end
            end else begin
                r_acc <= mul_sum;
                r_x   <= {r_x[WIDTH-2:0], 1'b0};
                r_y   <= {1'b0, r_y[WIDTH-1:1]};
            end
        end
    end

    always_comb begin
        o_div_by_zero = 1'b0;
        case (r_mode)
            MODE_ADD: o_result = r_x + r_y;
            MODE_SUB: o_result = r_x + ~r_y + 1'b1;
            MODE_MUL: begin
                if (r_force) o_result = r_force_one ? MSB : '1;
                else         o_result = r_acc;
            end
            default: begin
                o_div_by_zero = r_dz;
                if (r_dz)       o_result = '0;
                else if (r_neg) o_result = ~r_y + 1'b1;
                else            o_result = r_y;
            end
        endcase
    end

endmodule

// ===== rtl/signed_shift_add_alu_core.sv =====
// Channel   Valid     Ready     Payload
// input     i_valid   o_ready   i_mode, i_operand_a, i_operand_b
// output    o_valid   i_ready   o_result, o_div_by_zero
//
// Multiply and divide run a load step, WIDTH shift-add or trial-subtract
// steps on the shared iteration registers, and a sign fix-up step into the
// output register. Add and subtract skip the iteration steps.
// The step counter of the sequencer sets the number of steps; one word is
// in work at a time, and the next is taken the cycle after the result is
// registered. Reset (i_rst_n low at a clock edge) empties the output
// register and returns the sequencer to idle. A stalled output holds the
// finished word in the fix-up stage until the output register frees up.
module signed_shift_add_alu_core import ssa_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic signed [WIDTH-1:0] i_operand_a,
    input  logic signed [WIDTH-1:0] i_operand_b,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [WIDTH-1:0] o_result,
    output logic                    o_div_by_zero
);

    t_ctrl            s_ctrl;
    logic             s_out_free;
    logic [WIDTH-1:0] s_fix_result;
    logic             s_fix_dz;

    logic             r_valid;
    logic [WIDTH-1:0] r_result;
    logic             r_dz;

    // output register may take a word when empty or being drained
    assign s_out_free = !r_valid || i_ready;

    ssa_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_mode     (i_mode),
        .i_out_free (s_out_free),
        .o_ready    (o_ready),
        .o_ctrl     (s_ctrl)
    );

    ssa_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_ctrl        (s_ctrl),
        .i_mode        (i_mode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_result      (s_fix_result),
        .o_div_by_zero (s_fix_dz)
    );

    // hold the finished word until the consumer takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_ctrl.fire) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ctrl.fire) begin
            r_result <= s_fix_result;
            r_dz     <= s_fix_dz;
        end
    end

    assign o_valid       = r_valid;
    assign o_result      = r_result;
    assign o_div_by_zero = r_dz;

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.load |=> !o_ready)
        else $error("sequencer took a word and stayed idle");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.fire |=> o_valid)
        else $error("fix-up fired but output register is empty");

    a_dz_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_by_zero |-> o_result == '0)
        else $error("divide by zero flagged with non-zero result");

    a_no_fire_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_ctrl.fire |-> s_out_free)
        else $error("fix-up overwrote a pending output word");

endmodule

// ===== test/alu_result_checker.sv =====
module alu_result_checker import ssa_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  t_mode                   i_mode,
    input  logic signed [WIDTH-1:0] i_operand_a,
    input  logic signed [WIDTH-1:0] i_operand_b,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic signed [WIDTH-1:0] i_result,
    input  logic                    i_div_by_zero,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked
);

    typedef logic [WIDTH-1:0] t_word;

    typedef struct packed {
        t_word result;
        logic  div_by_zero;
    } t_alu_word;

    localparam t_word MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};

    t_alu_word expected_words[$];
    t_alu_word want;
    int        fail_count    = 0;
    int        checked_count = 0;

    function automatic t_word magnitude(t_word v);
        return v[WIDTH-1] ? -v : v;
    endfunction

    function automatic t_alu_word alu_compute(t_mode mode, t_word a, t_word b);
        t_alu_word    w;
        t_word        ma;
        t_word        mb;
        t_word        acc;
        logic [WIDTH:0] rem;
        w.result      = '0;
        w.div_by_zero = 1'b0;
        ma            = magnitude(a);
        mb            = magnitude(b);
        acc           = '0;
        rem           = '0;
        case (mode)
            MODE_ADD: w.result = a + b;
            MODE_SUB: w.result = a - b;
            MODE_MUL: begin
                if (a == '0 || b == '0) begin
                    w.result = '0;
                end else if (a == MOST_NEG || b == MOST_NEG) begin
                    w.result = (a == t_word'(1) || b == t_word'(1)) ? MOST_NEG : '1;
                end else begin
                    for (int k = 0; k < WIDTH; k++)
                        if (mb[k]) acc = acc + (ma << k);
                    w.result = (a[WIDTH-1] == b[WIDTH-1]) ? acc : -acc;
                end
            end
            MODE_DIV: begin
                if (b == '0) begin
                    w.div_by_zero = 1'b1;
                end else begin
                    // restoring division on magnitudes, sign fixed afterwards
                    for (int k = WIDTH - 1; k >= 0; k--) begin
                        rem = {rem[WIDTH-1:0], ma[k]};
                        if (rem >= {1'b0, mb}) begin
                            rem    = rem - {1'b0, mb};
                            acc[k] = 1'b1;
                        end
                    end
                    w.result = (a[WIDTH-1] == b[WIDTH-1]) ? acc : -acc;
                end
            end
        endcase
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                expected_words.push_back(alu_compute(i_mode, i_operand_a, i_operand_b));
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word %0d with nothing outstanding", i_result);
                    fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    checked_count++;
                    if (want.result !== i_result) begin
                        $error("result: expected %0d, got %0d",
                               $signed(want.result), i_result);
                        fail_count++;
                    end
                    if (want.div_by_zero !== i_div_by_zero) begin
                        $error("div_by_zero: expected %0d, got %0d",
                               want.div_by_zero, i_div_by_zero);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fail_count;
        o_checked    <= checked_count;
    end

endmodule

// ===== test/tb.sv =====
module tb;
    import ssa_pkg::*;

    localparam int WIDTH       = DEF_WIDTH;
    localparam int RANDOM_PER  = 330;    // random words per pacing phase
    localparam int STALL_LIMIT = 5000;   // cycles without any handshake
    localparam int TAIL_CYCLES = 2 * (WIDTH + 2);

    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    t_mode                   i_mode;
    logic signed [WIDTH-1:0] i_operand_a;
    logic signed [WIDTH-1:0] i_operand_b;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [WIDTH-1:0] o_result;
    logic                    o_div_by_zero;

    int fail_count;
    int pending_words;
    int checked_words;

    // idle odds in percent for each side, changed between phases
    int send_idle  = 0;
    int recv_idle  = 0;
    int words_sent = 0;
    int stall_cycles = 0;

    signed_shift_add_alu_core #(.WIDTH(WIDTH)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result      (o_result),
        .o_div_by_zero (o_div_by_zero)
    );

    alu_result_checker #(.WIDTH(WIDTH)) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_mode        (i_mode),
        .i_operand_a   (i_operand_a),
        .i_operand_b   (i_operand_b),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_result      (o_result),
        .i_div_by_zero (o_div_by_zero),
        .o_fail_count  (fail_count),
        .o_pending     (pending_words),
        .o_checked     (checked_words)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drop ready at random on the result side; one assignment per edge keeps
    // the stall pattern free of ordering effects.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Watchdog: count edges at which neither channel moves a word; a correct
    // block never goes this long even with both sides stalling.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[signed_shift_add_alu_core] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one word: idle for a random number of edges first, then raise
    // valid with the payload and hold both until the block takes the word.
    task automatic send_word(input t_mode mode, input logic [WIDTH-1:0] a,
                             input logic [WIDTH-1:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // Mix full-width noise with small values, the edges of the range and
    // shortened magnitudes, so that divide gives non-trivial quotients.
    function automatic logic [WIDTH-1:0] random_operand();
        logic [WIDTH-1:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $urandom_range(32) - 16;
            7: begin
                case ($urandom_range(4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '0;
                    3: v = 1;
                    default: v = '1;
                endcase
            end
            default: begin
                v = v >> $urandom_range(WIDTH - 1);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    initial begin
        t_mode mode;

        // Hold every input at a known value while reset is low.
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_ready     <= 1'b0;
        i_mode      <= MODE_ADD;
        i_operand_a <= '0;
        i_operand_b <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 23; recv_idle = 51; end
                1: begin send_idle = 51; recv_idle = 23; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase

            if (phase == 0) begin
                // wrap-around at the edges of the range
                send_word(MODE_ADD, MOST_POS, MOST_POS);
                send_word(MODE_ADD, MOST_NEG, MOST_NEG);
                send_word(MODE_SUB, MOST_NEG, 1);
                send_word(MODE_SUB, '0, MOST_NEG);
                send_word(MODE_SUB, MOST_POS, '1);
                // multiply: zero wins, then the most negative operand rules
                send_word(MODE_MUL, '0, 12345);
                send_word(MODE_MUL, MOST_NEG, '0);
                send_word(MODE_MUL, MOST_NEG, 1);
                send_word(MODE_MUL, 1, MOST_NEG);
                send_word(MODE_MUL, MOST_NEG, MOST_NEG);
                send_word(MODE_MUL, MOST_NEG, 5);
                send_word(MODE_MUL, '1, '1);
                send_word(MODE_MUL, MOST_POS, MOST_POS);
                send_word(MODE_MUL, -7, 6);
                // divide: zero divisor, most negative corners, truncation
                send_word(MODE_DIV, 99, '0);
                send_word(MODE_DIV, MOST_NEG, '0);
                send_word(MODE_DIV, MOST_NEG, MOST_NEG);
                send_word(MODE_DIV, 5, MOST_NEG);
                send_word(MODE_DIV, MOST_NEG, '1);
                send_word(MODE_DIV, -7, 2);
                send_word(MODE_DIV, 7, -2);
                send_word(MODE_DIV, MOST_POS, 1);
                send_word(MODE_DIV, '0, 3);
            end

            repeat (RANDOM_PER) begin
                mode = t_mode'($urandom_range(3));
                send_word(mode, random_operand(), random_operand());
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every outstanding result, then keep the inputs quiet so
        // that any stray word is caught.
        do @(posedge i_clk); while (pending_words != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d words over add, subtract, multiply and divide, with range",
                 words_sent);
        $display("edges, zero divisors and three pacing phases; %0d results compared.",
                 checked_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("[signed_shift_add_alu_core] OK");
        end else begin
            $display("[signed_shift_add_alu_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== signed_shift_add_alu_core.f =====
rtl/ssa_pkg.sv
rtl/ssa_ctrl.sv
rtl/ssa_dp.sv
rtl/signed_shift_add_alu_core.sv
test/alu_result_checker.sv
test/tb.sv
